// ----- hdl/fan_speed_pi_controller_defines.svh -----
// Assertion macros used by the checker file.
`ifndef FAN_SPEED_PI_CONTROLLER_DEFINES_SVH
`define FAN_SPEED_PI_CONTROLLER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define FSPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define FSPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fspc_pkg.sv -----
package fspc_pkg;

    localparam int GAIN_FRAC_BITS_DEF   = 8;
    localparam int ACC_FRAC_BITS_DEF    = 8;
    localparam int STALL_TIMEOUT_US_DEF = 500000;

    localparam logic [15:0] FULL_DUTY    = 16'hFFFF;
    localparam logic [31:0] USEC_PER_MIN = 32'd60000000;

    localparam logic [1:0] CMD_EDGE   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_TARGET = 2'd2;
    localparam logic [1:0] CMD_DUTY   = 2'd3;

    localparam logic [2:0] REG_TACH  = 3'd0;
    localparam logic [2:0] REG_MAX   = 3'd1;
    localparam logic [2:0] REG_PPR   = 3'd2;
    localparam logic [2:0] REG_PGAIN = 3'd3;
    localparam logic [2:0] REG_IGAIN = 3'd4;
    localparam logic [2:0] REG_MINUP = 3'd5;

    // Datapath operations requested by the controller.
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_RPM_DIV  = 4'd2;
    localparam logic [3:0] OP_RPM_DONE = 4'd3;
    localparam logic [3:0] OP_STEP_CHK = 4'd4;
    localparam logic [3:0] OP_TGT_DIV  = 4'd5;
    localparam logic [3:0] OP_MEAS_DIV = 4'd6;
    localparam logic [3:0] OP_PI_MUL   = 4'd7;
    localparam logic [3:0] OP_PI_SUM   = 4'd8;
    localparam logic [3:0] OP_OL_DIV   = 4'd9;
    localparam logic [3:0] OP_OL_DONE  = 4'd10;
    localparam logic [3:0] OP_DIV_STEP = 4'd11;

    typedef struct packed {
        logic [3:0] op;
        logic       div_start;
    } fspc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic meas_ok;
        logic step_ok;
        logic tgt_set;
        logic first;
        logic tach;
    } fspc_stat_t;

endpackage

// ----- hdl/fan_speed_pi_controller.sv -----
// Channel  | Handshake              | Payload
// input    | valid / stall          | cmd, value, now_us, now_ms
// output   | out_valid / out_stall  | duty_valid, duty, speed_rpm, target_active
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Items are handled one at a time. A closed-loop update uses up to three runs
// of the shared bit-serial divider (40 quotient bits, one per cycle) for the
// rpm and the two pwm conversions; an open-loop update needs at most one run.
// Reset is asynchronous and restores the register defaults. A stalled result
// holds the block until it transfers.
module fan_speed_pi_controller
    import fspc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF,
    parameter int ACC_FRAC_BITS    = ACC_FRAC_BITS_DEF,
    parameter int STALL_TIMEOUT_US = STALL_TIMEOUT_US_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] value,
    input  logic [31:0] now_us,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        duty_valid,
    output logic [15:0] duty,
    output logic [15:0] speed_rpm,
    output logic        target_active,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    fspc_cmd_t  ctl;
    fspc_stat_t stat;
    logic       issue;

    // Configuration is always taken; the user must write only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    fspc_control u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid),
        .in_stall  (stall),
        .in_cmd    (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .issue     (issue),
        .ctl       (ctl),
        .stat      (stat)
    );

    fspc_datapath #(
        .GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
        .ACC_FRAC_BITS    (ACC_FRAC_BITS),
        .STALL_TIMEOUT_US (STALL_TIMEOUT_US)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .in_cmd        (cmd),
        .in_value      (value),
        .in_now_us     (now_us),
        .in_now_ms     (now_ms),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_idx       (cfg_index),
        .cfg_data      (cfg_data),
        .issue         (issue),
        .duty          (duty),
        .speed_rpm     (speed_rpm),
        .target_active (target_active)
    );

    assign duty_valid = issue;

endmodule

// ----- hdl/fspc_divider.sv -----
module fspc_divider
    import fspc_pkg::*;
#(
    parameter int W = 48
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    trial;

    // One restoring quotient bit per cycle.
    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        trial    = {r_reg, q_reg[W-1]};
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = CW'(W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, d_reg})
            begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;

endmodule

// ----- hdl/fspc_datapath.sv -----
module fspc_datapath
    import fspc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF,
    parameter int ACC_FRAC_BITS    = ACC_FRAC_BITS_DEF,
    parameter int STALL_TIMEOUT_US = STALL_TIMEOUT_US_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  fspc_cmd_t   ctl,
    output fspc_stat_t  stat,
    input  logic [1:0]  in_cmd,
    input  logic [15:0] in_value,
    input  logic [31:0] in_now_us,
    input  logic [31:0] in_now_ms,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [15:0] cfg_data,
    input  logic        issue,
    output logic [15:0] duty,
    output logic [15:0] speed_rpm,
    output logic        target_active
);

    localparam int PW = 16 + ACC_FRAC_BITS;
    localparam int DW = 32 + ACC_FRAC_BITS;
    localparam int SW = PW + 18 + 1;
    localparam logic [PW-1:0] PWM_MAX = PW'({FULL_DUTY, {ACC_FRAC_BITS{1'b0}}});

    logic        tach_reg;
    logic [15:0] max_reg;
    logic [7:0]  ppr_reg;
    logic signed [15:0] pg_reg, ig_reg;
    logic [15:0] minup_reg;

    logic [1:0]  cmd_reg;
    logic [15:0] val_reg;
    logic [31:0] us_reg, ms_reg;

    logic [7:0]  edge_cnt_reg;
    logic [31:0] stamp_reg, stamp_prev_reg;
    logic [15:0] rpm_reg, tgt_reg, duty_reg;
    logic        tset_reg, first_reg;
    logic [PW-1:0] prev_reg, acc_reg, tgt_pwm_reg, meas_pwm_reg;
    logic [31:0] last_ms_reg;
    logic signed [SW-1:0] pprod_reg, iprod_reg;

    logic          div_start;
    logic [DW-1:0] div_a, div_b, div_q;
    logic          div_busy;

    logic [15:0] eff_max;
    logic [31:0] period;
    logic [PW-1:0] pwm_q;
    logic signed [SW-1:0] p_term, i_term, acc_sum;
    logic [PW:0] rnd;
    logic [7:0]  edge_inc;

    assign eff_max  = (max_reg == '0) ? 16'd1 : max_reg;
    assign period   = stamp_reg - stamp_prev_reg;
    assign edge_inc = edge_cnt_reg + 1'b1;
    assign pwm_q    = (div_q > DW'(PWM_MAX)) ? PWM_MAX : div_q[PW-1:0];
    assign p_term   = pprod_reg >>> GAIN_FRAC_BITS;
    assign i_term   = iprod_reg >>> GAIN_FRAC_BITS;
    assign acc_sum  = $signed({1'b0, acc_reg}) + p_term + i_term;
    // Rounds the new accumulator value half up to whole duty counts.
    assign rnd      = (ACC_FRAC_BITS > 0)
                    ? ({1'b0, acc_sum[PW-1:0]} + (PW+1)'((PW+1)'(1) << ACC_FRAC_BITS) / 2)
                    : {1'b0, acc_sum[PW-1:0]};

    // Divider operands follow the requested operation.
    always_comb
    begin
        div_start = ctl.div_start;
        div_a     = '0;
        div_b     = DW'(eff_max);
        case (ctl.op)
            OP_RPM_DIV:
            begin
                div_a = DW'(USEC_PER_MIN);
                div_b = DW'(period);
            end
            OP_TGT_DIV:
                div_a = DW'({DW'(tgt_reg) * DW'(FULL_DUTY)} << ACC_FRAC_BITS);
            OP_MEAS_DIV:
                div_a = DW'({DW'(rpm_reg) * DW'(FULL_DUTY)} << ACC_FRAC_BITS);
            OP_OL_DIV:
                div_a = DW'(tgt_reg) * DW'(FULL_DUTY) + DW'(eff_max[15:1]);
            default:
                div_a = '0;
        endcase
    end

    fspc_divider #(.W(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tach_reg       <= 1'b1;
            max_reg        <= 16'd3000;
            ppr_reg        <= 8'd2;
            pg_reg         <= 16'sd256;
            ig_reg         <= 16'sd32;
            minup_reg      <= '0;
            edge_cnt_reg   <= '0;
            stamp_reg      <= '0;
            stamp_prev_reg <= '0;
            rpm_reg        <= '0;
            tgt_reg        <= '0;
            tset_reg       <= 1'b0;
            first_reg      <= 1'b1;
            prev_reg       <= '0;
            acc_reg        <= '0;
            last_ms_reg    <= '0;
            duty_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_TACH:  tach_reg  <= cfg_data[0];
                    REG_MAX:   max_reg   <= cfg_data;
                    REG_PPR:   ppr_reg   <= cfg_data[7:0];
                    REG_PGAIN: pg_reg    <= cfg_data;
                    REG_IGAIN: ig_reg    <= cfg_data;
                    REG_MINUP: minup_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (ctl.op)
                OP_LOAD:
                begin
                    case (in_cmd)
                        CMD_EDGE:
                        begin
                            if (edge_inc == ppr_reg)
                            begin
                                stamp_prev_reg <= stamp_reg;
                                stamp_reg      <= in_now_us;
                                edge_cnt_reg   <= '0;
                            end
                            else
                                edge_cnt_reg <= edge_inc;
                        end
                        CMD_TARGET:
                        begin
                            tgt_reg  <= (in_value > eff_max) ? eff_max : in_value;
                            tset_reg <= 1'b1;
                        end
                        CMD_DUTY:
                        begin
                            duty_reg <= in_value;
                            tset_reg <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                OP_RPM_DONE:
                begin
                    if ((us_reg - stamp_reg) > 32'(STALL_TIMEOUT_US))
                        rpm_reg <= '0;
                    else if (period == '0 || div_q > DW'(FULL_DUTY))
                        rpm_reg <= FULL_DUTY;
                    else
                        rpm_reg <= div_q[15:0];
                end
                OP_STEP_CHK:
                begin
                    if (stat.step_ok)
                        last_ms_reg <= ms_reg;
                end
                OP_MEAS_DIV:
                begin
                    // The target quotient is still in the divider when the
                    // measurement division starts.
                    if (ctl.div_start)
                        tgt_pwm_reg <= pwm_q;
                end
                OP_PI_MUL:
                begin
                    meas_pwm_reg <= pwm_q;
                    if (first_reg)
                    begin
                        prev_reg  <= pwm_q;
                        acc_reg   <= '0;
                        first_reg <= 1'b0;
                    end
                end
                OP_PI_SUM:
                begin
                    prev_reg <= meas_pwm_reg;
                    if (acc_sum > $signed(SW'(PWM_MAX)))
                    begin
                        acc_reg  <= PWM_MAX;
                        duty_reg <= FULL_DUTY;
                    end
                    else if (acc_sum < 0)
                    begin
                        acc_reg  <= '0;
                        duty_reg <= '0;
                    end
                    else
                    begin
                        acc_reg  <= acc_sum[PW-1:0];
                        duty_reg <= (rnd[PW:ACC_FRAC_BITS] > (PW+1-ACC_FRAC_BITS)'(FULL_DUTY))
                                  ? FULL_DUTY : 16'(rnd[PW:ACC_FRAC_BITS]);
                    end
                end
                OP_OL_DONE:
                begin
                    duty_reg <= (div_q > DW'(FULL_DUTY)) ? FULL_DUTY : div_q[15:0];
                    tset_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Input item and PI products; no reset needed.
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LOAD)
        begin
            cmd_reg <= in_cmd;
            val_reg <= in_value;
            us_reg  <= in_now_us;
            ms_reg  <= in_now_ms;
        end
        if (ctl.op == OP_PI_MUL)
        begin
            pprod_reg <= SW'(pg_reg * $signed({2'b0, (first_reg ? pwm_q : prev_reg)})
                         - pg_reg * $signed({2'b0, pwm_q}));
            iprod_reg <= SW'(ig_reg * $signed({2'b0, tgt_pwm_reg})
                         - ig_reg * $signed({2'b0, pwm_q}));
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.meas_ok  = (stamp_reg >= stamp_prev_reg) && (stamp_prev_reg != '0);
    assign stat.step_ok  = (minup_reg == '0) || ((ms_reg - last_ms_reg) >= 32'(minup_reg));
    assign stat.tgt_set  = tset_reg;
    assign stat.first    = first_reg;
    assign stat.tach     = tach_reg;

    assign duty          = duty_reg;
    assign speed_rpm     = rpm_reg;
    assign target_active = tset_reg;

    logic unused;
    assign unused = ^{cmd_reg, val_reg, issue};

endmodule

// ----- hdl/fspc_control.sv -----
module fspc_control
    import fspc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] in_cmd,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       issue,
    output fspc_cmd_t  ctl,
    input  fspc_stat_t stat
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RPM_GO   = 4'd1;
    localparam logic [3:0] S_RPM_WAIT = 4'd2;
    localparam logic [3:0] S_RPM_END  = 4'd3;
    localparam logic [3:0] S_CHK      = 4'd4;
    localparam logic [3:0] S_TGT_WAIT = 4'd5;
    localparam logic [3:0] S_MEAS_GO  = 4'd6;
    localparam logic [3:0] S_MEAS_WT  = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_SUM      = 4'd9;
    localparam logic [3:0] S_OL_WAIT  = 4'd10;
    localparam logic [3:0] S_OL_END   = 4'd11;
    localparam logic [3:0] S_OUT      = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       issue_reg, issue_next;
    logic       accept;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next    = state_reg;
        issue_next    = issue_reg;
        ctl.op        = OP_NONE;
        ctl.div_start = 1'b0;
        in_stall      = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    ctl.op     = OP_LOAD;
                    issue_next = (in_cmd == CMD_DUTY);
                    if (in_cmd == CMD_UPDATE)
                        state_next = stat.tach ? S_RPM_GO : S_OL_WAIT;
                    else
                        state_next = S_OUT;
                end
            end
            S_RPM_GO:
            begin
                if (stat.meas_ok)
                begin
                    ctl.op        = OP_RPM_DIV;
                    ctl.div_start = 1'b1;
                    state_next    = S_RPM_WAIT;
                end
                else
                    state_next = S_CHK;
            end
            S_RPM_WAIT:
            begin
                ctl.op = OP_RPM_DIV;
                if (!stat.div_busy)
                    state_next = S_RPM_END;
            end
            S_RPM_END:
            begin
                ctl.op     = OP_RPM_DONE;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                ctl.op = OP_STEP_CHK;
                if (!stat.step_ok)
                    state_next = S_OUT;
                else if (stat.tgt_set)
                begin
                    ctl.op        = OP_STEP_CHK;
                    state_next    = S_TGT_WAIT;
                end
                else if (stat.first)
                    state_next = S_MEAS_GO;
                else
                    state_next = S_OUT;
            end
            S_TGT_WAIT:
            begin
                ctl.op = OP_TGT_DIV;
                if (!stat.div_busy && state_reg == S_TGT_WAIT && issue_reg)
                    state_next = S_MEAS_GO;
                else if (!stat.div_busy)
                begin
                    ctl.div_start = 1'b1;
                    issue_next    = 1'b1;
                end
            end
            S_MEAS_GO:
            begin
                ctl.op        = OP_MEAS_DIV;
                ctl.div_start = 1'b1;
                state_next    = S_MEAS_WT;
            end
            S_MEAS_WT:
            begin
                ctl.op = OP_MEAS_DIV;
                if (!stat.div_busy)
                begin
                    ctl.op     = OP_PI_MUL;
                    state_next = issue_reg ? S_SUM : S_OUT;
                end
            end
            S_MUL:
                state_next = S_SUM;
            S_SUM:
            begin
                ctl.op     = OP_PI_SUM;
                state_next = S_OUT;
            end
            S_OL_WAIT:
            begin
                ctl.op = OP_OL_DIV;
                if (!stat.tgt_set)
                    state_next = S_OUT;
                else if (!stat.div_busy && issue_reg)
                    state_next = S_OL_END;
                else if (!stat.div_busy)
                begin
                    ctl.div_start = 1'b1;
                    issue_next    = 1'b1;
                end
            end
            S_OL_END:
            begin
                ctl.op     = OP_OL_DONE;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            issue_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
        end
    end

    assign out_valid = (state_reg == S_OUT);
    assign issue     = issue_reg;

endmodule

// ----- hdl/fspc_checker.sv -----
module fspc_checker
    import fspc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] duty
);

`include "fan_speed_pi_controller_defines.svh"

    `FSPC_ASSERT_IMP(a_no_take_while_out, out_valid, stall, "input taken while result pending")
    `FSPC_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(duty), "result dropped")
    `FSPC_ASSERT_NEXT(a_out_ends, out_valid && !out_stall, !out_valid, "result repeated")

endmodule

bind fan_speed_pi_controller fspc_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (valid),
    .stall      (stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .duty       (duty)
);
